### rtl/pixel_desaturate_vignette_assert.svh
// assertion macros used by the checker file of pixel_desaturate_vignette
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef PIXEL_DESATURATE_VIGNETTE_ASSERT_SVH
`define PIXEL_DESATURATE_VIGNETTE_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define PDV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define PDV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define PDV_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pdv_pkg.sv
// shared widths, register codes, reset values and structs of pixel_desaturate_vignette
// depends on nothing
`timescale 1ns / 1ps

package pdv_pkg;

  // field widths
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned DIM_W       = 16;
  localparam int unsigned BORDER_W    = 10;
  localparam int unsigned GREY_W      = 8;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned LUMA_SUM_W  = 12;  // 3r+6g+b tops out at 2550
  localparam int unsigned IN_TDATA_W  = 3 * COLOR_W;
  localparam int unsigned OUT_TDATA_W = GREY_W + WORD_W;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 2;

  // register indexes (byte address / 4)
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BORDER_WIDTH = 2'd2;

  // register reset values
  localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 16'd1280;
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 16'd768;
  localparam logic [BORDER_W-1:0] BORDER_WIDTH_RST = 10'd100;

  // pixel constants
  localparam logic [GREY_W-1:0] GREY_MAX     = 8'd255;
  localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;

  // divide by ten as multiply by 3277 / 2^15, exact for sums up to 2550
  localparam logic [LUMA_SUM_W-1:0] DIV10_MULT  = 12'd3277;
  localparam int unsigned           DIV10_SHIFT = 15;

  typedef struct packed {
    logic [DIM_W-1:0]    frame_width;
    logic [DIM_W-1:0]    frame_height;
    logic [BORDER_W-1:0] border_width;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] column;
    logic [DIM_W-1:0] row;
    logic             last;
  } pos_t;

endpackage

### rtl/pdv_cfg_regs.sv
// apb-style configuration registers: frame width, frame height, border width
// depends on pdv_pkg
`timescale 1ns / 1ps

module pdv_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pdv_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [pdv_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [pdv_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output pdv_pkg::cfg_t                    cfg
);

  pdv_pkg::cfg_t                  cfg_r;
  logic                           wr_en;
  logic [pdv_pkg::REG_IDX_W-1:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[pdv_pkg::CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  // register writes, other indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= pdv_pkg::FRAME_WIDTH_RST;
      cfg_r.frame_height <= pdv_pkg::FRAME_HEIGHT_RST;
      cfg_r.border_width <= pdv_pkg::BORDER_WIDTH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        pdv_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_pwdata[pdv_pkg::DIM_W-1:0];
        pdv_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_pwdata[pdv_pkg::DIM_W-1:0];
        pdv_pkg::REG_BORDER_WIDTH: cfg_r.border_width <= cfg_pwdata[pdv_pkg::BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      pdv_pkg::REG_FRAME_WIDTH:
        cfg_prdata = {{(pdv_pkg::CFG_DATA_W-pdv_pkg::DIM_W){1'b0}}, cfg_r.frame_width};
      pdv_pkg::REG_FRAME_HEIGHT:
        cfg_prdata = {{(pdv_pkg::CFG_DATA_W-pdv_pkg::DIM_W){1'b0}}, cfg_r.frame_height};
      pdv_pkg::REG_BORDER_WIDTH:
        cfg_prdata = {{(pdv_pkg::CFG_DATA_W-pdv_pkg::BORDER_W){1'b0}}, cfg_r.border_width};
      default:
        cfg_prdata = '0;
    endcase
  end

endmodule

### rtl/pdv_pos_count.sv
// raster position counters: column and row of the next pixel, wrap at frame size
// depends on pdv_pkg
`timescale 1ns / 1ps

module pdv_pos_count (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  pdv_pkg::cfg_t cfg,
  output pdv_pkg::pos_t pos
);

  logic [pdv_pkg::DIM_W-1:0] col_r, col_nxt;
  logic [pdv_pkg::DIM_W-1:0] row_r, row_nxt;
  logic                      last_col;
  logic                      last_row;

  // a size of zero behaves like one: every position is the last
  assign last_col = ({1'b0, col_r} + 1'b1) >= {1'b0, cfg.frame_width};
  assign last_row = ({1'b0, row_r} + 1'b1) >= {1'b0, cfg.frame_height};

  assign pos.column = col_r;
  assign pos.row    = row_r;
  assign pos.last   = last_col && last_row;

  // next position
  always_comb begin
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### rtl/pdv_shade.sv
// grey level from the weighted rgb sum, darkened by the edge vignette
// depends on pdv_pkg; purely combinational, sits between the two pipeline registers
`timescale 1ns / 1ps

module pdv_shade (
  input  logic [pdv_pkg::LUMA_SUM_W-1:0] luma_sum,
  input  pdv_pkg::pos_t                  pos,
  input  pdv_pkg::cfg_t                  cfg,
  output logic [pdv_pkg::GREY_W-1:0]     grey
);

  localparam int unsigned SGN_W  = pdv_pkg::DIM_W + 2;
  localparam int unsigned EDGE_W = pdv_pkg::DIM_W + 1;
  localparam int unsigned AMT_W  = EDGE_W + 1;
  localparam int unsigned PROD_W = 2 * pdv_pkg::LUMA_SUM_W;
  localparam int unsigned LUMA_W = PROD_W - pdv_pkg::DIV10_SHIFT;

  logic [PROD_W-1:0]          prod;
  logic [LUMA_W-1:0]          luma_q;
  logic [pdv_pkg::GREY_W-1:0] luma;
  logic [AMT_W-1:0]           amount;

  // darkening from one axis; both terms are positive when they apply
  function automatic logic [EDGE_W-1:0] edge_amount(
    input logic [pdv_pkg::DIM_W-1:0]    p_in,
    input logic [pdv_pkg::DIM_W-1:0]    size_in,
    input logic [pdv_pkg::BORDER_W-1:0] border_in
  );
    logic signed [SGN_W-1:0] p;
    logic signed [SGN_W-1:0] s;
    logic signed [SGN_W-1:0] b;
    logic signed [SGN_W-1:0] amt;
    p   = signed'({2'b00, p_in});
    s   = signed'({2'b00, size_in});
    b   = signed'({{(SGN_W-pdv_pkg::BORDER_W){1'b0}}, border_in});
    amt = '0;
    if (p < b)
      amt = amt + (b - p);
    if (p > s - b)
      amt = amt + (b - (s - p));
    return amt[EDGE_W-1:0];
  endfunction

  // divide by ten through the reciprocal
  assign prod   = luma_sum * pdv_pkg::DIV10_MULT;
  assign luma_q = prod[PROD_W-1:pdv_pkg::DIV10_SHIFT];
  assign luma   = (luma_q > LUMA_W'(pdv_pkg::GREY_MAX)) ? pdv_pkg::GREY_MAX
                                                       : luma_q[pdv_pkg::GREY_W-1:0];

  // vignette amount over both axes
  assign amount = {1'b0, edge_amount(pos.column, cfg.frame_width, cfg.border_width)}
                + {1'b0, edge_amount(pos.row, cfg.frame_height, cfg.border_width)};

  // subtract, saturating at zero
  always_comb begin
    if (amount >= AMT_W'(luma))
      grey = '0;
    else
      grey = luma - amount[pdv_pkg::GREY_W-1:0];
  end

endmodule

### rtl/pixel_desaturate_vignette.sv
// top level of pixel_desaturate_vignette: stream ports, apb port, two-register pipeline
// depends on pdv_pkg, pdv_cfg_regs, pdv_pos_count, pdv_shade
`timescale 1ns / 1ps

// Converts a raster-order RGB pixel stream into grey pixels, (3R+6G+B)/10,
// darkened near the frame edges by a vignette of configurable border width,
// and emits each as a grey byte plus an opaque ARGB word, with tlast on the
// frame's last pixel. One pixel is accepted every clock while the output is
// taken; a pixel passes through the input register (which also captures the
// raster position and the weighted RGB sum) and then the result register
// (after the divide-by-ten multiply and vignette subtract). The result
// register frees itself when out_tready is high, so a stalled output still
// lets one more beat into the input register.
// Frame size and border width are written through the APB port between
// frames; the position counters are not cleared by a register write.

module pixel_desaturate_vignette (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel in
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pdv_pkg::IN_TDATA_W-1:0]     in_tdata,   // red_in, green_in, blue_in
  // pixel out
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pdv_pkg::OUT_TDATA_W-1:0]    out_tdata,  // grey_out, pixel_word
  output logic                               out_tlast,  // frame_end
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pdv_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [pdv_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [pdv_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int unsigned CW = pdv_pkg::COLOR_W;
  localparam int unsigned SW = pdv_pkg::LUMA_SUM_W;

  pdv_pkg::cfg_t               cfg;
  pdv_pkg::pos_t               pos;
  logic                        in_acc;
  logic                        s1_ready;
  logic                        s2_ready;
  logic                        s1_move;
  logic [CW-1:0]               red, green, blue;
  logic [SW-1:0]               sum_nxt;
  logic                        s1_valid_r;
  logic [SW-1:0]               s1_sum_r;
  pdv_pkg::pos_t               s1_pos_r;
  logic [pdv_pkg::GREY_W-1:0]  grey_nxt;
  logic                        out_valid_r;
  logic [pdv_pkg::GREY_W-1:0]  out_grey_r;
  logic                        out_last_r;

  pdv_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pdv_pos_count u_pos_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_acc),
    .cfg     (cfg),
    .pos     (pos)
  );

  // pipeline handshake
  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign s1_move   = s1_valid_r && s2_ready;
  assign in_tready = s1_ready;
  assign in_acc    = in_tvalid && s1_ready;

  // weighted rgb sum by shift and add
  assign red     = in_tdata[CW-1:0];
  assign green   = in_tdata[2*CW-1:CW];
  assign blue    = in_tdata[3*CW-1:2*CW];
  assign sum_nxt = ({{(SW-CW){1'b0}}, red} << 1) + {{(SW-CW){1'b0}}, red}
                 + ({{(SW-CW){1'b0}}, green} << 2) + ({{(SW-CW){1'b0}}, green} << 1)
                 + {{(SW-CW){1'b0}}, blue};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_valid_r <= 1'b0;
    else if (s1_ready)
      s1_valid_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sum_r <= sum_nxt;
      s1_pos_r <= pos;
    end
  end

  pdv_shade u_shade (
    .luma_sum (s1_sum_r),
    .pos      (s1_pos_r),
    .cfg      (cfg),
    .grey     (grey_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (s2_ready)
      out_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_grey_r <= grey_nxt;
      out_last_r <= s1_pos_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {pdv_pkg::ALPHA_OPAQUE, out_grey_r, out_grey_r, out_grey_r, out_grey_r};

endmodule

### rtl/pdv_checker.sv
// port-level checker for pixel_desaturate_vignette, with its bind
// depends on pdv_pkg and pixel_desaturate_vignette_assert.svh
`timescale 1ns / 1ps
`include "pixel_desaturate_vignette_assert.svh"

module pdv_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [pdv_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pdv_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            cfg_psel,
  input logic                            cfg_penable,
  input logic                            cfg_pwrite,
  input logic [pdv_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input logic [pdv_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  input logic [pdv_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  input logic                            cfg_pready
);

  localparam int unsigned GW = pdv_pkg::GREY_W;

  logic cfg_wr;
  logic width_sel;

  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign width_sel = (cfg_paddr[pdv_pkg::CFG_ADDR_W-1:2] == pdv_pkg::REG_FRAME_WIDTH);

  // reset empties the pipeline
  `PDV_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, !rst_n, !out_tvalid, "output valid after reset")

  // a stalled result beat holds
  `PDV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output beat changed")

  // argb word is opaque and carries the grey byte in every channel
  `PDV_ASSERT_NOW(a_word_grey, clk, rst_n, out_tvalid,
    (out_tdata[GW+31:GW+24] == pdv_pkg::ALPHA_OPAQUE)
    && (out_tdata[GW+23:GW+16] == out_tdata[GW-1:0])
    && (out_tdata[GW+15:GW+8] == out_tdata[GW-1:0])
    && (out_tdata[GW+7:GW] == out_tdata[GW-1:0]), "pixel word does not match grey")

  // a read of frame width right after a write to it returns the written value
  `PDV_ASSERT_NOW(a_width_readback, clk, rst_n,
    cfg_psel && !cfg_pwrite && width_sel && $past(rst_n && cfg_wr && width_sel),
    cfg_prdata == {{(pdv_pkg::CFG_DATA_W-pdv_pkg::DIM_W){1'b0}},
                   $past(cfg_pwdata[pdv_pkg::DIM_W-1:0])}, "frame width readback mismatch")

endmodule

bind pixel_desaturate_vignette pdv_checker u_pdv_checker (.*);
